FILE: rtl/etf_pkg.sv
package etf_pkg;

  localparam int CoordWidth  = 32;
  localparam int FracBitsDef = 28;
  localparam int CountWidth  = 16;
  localparam int ColorWidth  = 24;

  typedef struct packed {
    logic signed [CoordWidth-1:0] c_real;
    logic signed [CoordWidth-1:0] c_imag;
    logic signed [CoordWidth-1:0] start_real;
    logic signed [CoordWidth-1:0] start_imag;
  } etf_in_t;

  typedef struct packed {
    logic [CountWidth-1:0] iteration_count;
    logic                  escaped;
    logic [ColorWidth-1:0] pixel_color;
  } etf_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MRR,
    ST_MII,
    ST_MRI,
    ST_CHK,
    ST_SRR,
    ST_SII,
    ST_CMP,
    ST_FIN
  } etf_state_e;

  // sequencer commands to the datapath
  typedef struct packed {
    logic busy;
    logic load_in;
    logic sel_a_imag;
    logic sel_b_imag;
    logic acc_load;
    logic acc_sub;
    logic z_update;
    logic count_inc;
    logic esc_set;
    logic out_load;
  } etf_ctl_t;

  // datapath status to the sequencer
  typedef struct packed {
    logic in_valid;
    logic over_two;
    logic sum_over;
    logic count_last;
    logic limit_zero;
    logic out_free;
  } etf_sts_t;

endpackage

FILE: rtl/escape_time_fractal_pixel.sv
// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_stall_o   | in_data_i   (etf_in_t)
// out     | output    | out_valid_o / out_stall_i | out_data_o  (etf_out_t)
// cfg     | input     | cfg_wr_en_i               | cfg_wr_data_i (iteration_limit)
//
// one shared signed multiplier does five products per update, plus a range check
// and a magnitude compare step
// an item can leave an update early, at the range check
// rst_ni clears the sequencer, the output valid and sets the limit to 64
// in_stall_o is high from acceptance until the result is loaded into the output register
// a result waiting under out_stall_i holds the block in its final step
module escape_time_fractal_pixel import etf_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  etf_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output etf_out_t              out_data_o,
  input  logic                  cfg_wr_en_i,
  input  logic [CountWidth-1:0] cfg_wr_data_i
);

  localparam int OpW   = (CoordWidth >= FRAC_BITS + 3) ? CoordWidth : FRAC_BITS + 3;
  localparam int ProdW = 2 * OpW;
  localparam logic [CountWidth-1:0] LimitReset = CountWidth'(64);
  localparam logic signed [ProdW:0] Bound    = (ProdW+1)'(1) << (FRAC_BITS + 1);
  localparam logic signed [ProdW:0] NegBound = -Bound;
  localparam logic signed [ProdW:0] Four     = (ProdW+1)'(1) << (2 * FRAC_BITS + 2);
  localparam logic [7:0] ColorFull = 8'hFF;
  localparam logic [7:0] RedStep   = 8'd15;
  localparam logic [7:0] BlueStep  = 8'd5;

  etf_ctl_t ctl;
  etf_sts_t sts;

  logic [CountWidth-1:0] limit_q;
  logic [CountWidth-1:0] count_q;
  logic [CountWidth-1:0] count_d;
  logic                  esc_q;
  logic                  esc_d;
  logic signed [OpW-1:0] cr_q;
  logic signed [OpW-1:0] ci_q;
  logic signed [OpW-1:0] zr_q;
  logic signed [OpW-1:0] zr_d;
  logic signed [OpW-1:0] zi_q;
  logic signed [OpW-1:0] zi_d;
  logic signed [ProdW:0] acc_q;
  logic signed [ProdW:0] acc_d;
  logic signed [OpW-1:0] mul_a;
  logic signed [OpW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW:0] re_full;
  logic signed [ProdW:0] im_full;
  logic signed [ProdW:0] mag_sum;
  logic                  out_valid_q;
  etf_out_t              out_q;
  etf_out_t              out_d;
  logic [7:0]            red;
  logic [7:0]            blue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_wr_en_i) begin
      limit_q <= cfg_wr_data_i;
    end
  end

  assign mul_a = ctl.sel_a_imag ? zi_q : zr_q;
  assign mul_b = ctl.sel_b_imag ? zi_q : zr_q;

  etf_mul #(
    .OpW(OpW)
  ) u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  // new point: real from zr^2 - zi^2, imaginary from 2*zr*zi
  assign re_full = (acc_q >>> FRAC_BITS) + (ProdW+1)'(cr_q);
  assign im_full = (ProdW+1)'(prod >>> (FRAC_BITS - 1)) + (ProdW+1)'(ci_q);
  assign mag_sum = acc_q + (ProdW+1)'(prod);

  assign sts.in_valid   = in_valid_i;
  assign sts.over_two   = (re_full > Bound) || (re_full < NegBound) ||
                          (im_full > Bound) || (im_full < NegBound);
  assign sts.sum_over   = (mag_sum > Four);
  assign sts.count_last = ((CountWidth+1)'(count_q) + (CountWidth+1)'(1)) ==
                          (CountWidth+1)'(limit_q);
  assign sts.limit_zero = (limit_q == '0);
  assign sts.out_free   = !out_valid_q || !out_stall_i;

  etf_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .sts_i (sts),
    .ctl_o (ctl)
  );

  always_comb begin
    acc_d = acc_q;
    if (ctl.acc_load) begin
      acc_d = (ProdW+1)'(prod);
    end else if (ctl.acc_sub) begin
      acc_d = acc_q - (ProdW+1)'(prod);
    end
  end

  always_comb begin
    zr_d    = zr_q;
    zi_d    = zi_q;
    count_d = count_q;
    esc_d   = esc_q;
    if (ctl.load_in) begin
      zr_d    = OpW'($signed(in_data_i.start_real));
      zi_d    = OpW'($signed(in_data_i.start_imag));
      count_d = '0;
      esc_d   = 1'b0;
    end else begin
      if (ctl.z_update) begin
        // only kept when within range, so the truncation is exact
        zr_d = re_full[OpW-1:0];
        zi_d = im_full[OpW-1:0];
      end
      if (ctl.count_inc) begin
        count_d = count_q + CountWidth'(1);
      end
      if (ctl.esc_set) begin
        esc_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.load_in) begin
      cr_q <= OpW'($signed(in_data_i.c_real));
      ci_q <= OpW'($signed(in_data_i.c_imag));
    end
    zr_q    <= zr_d;
    zi_q    <= zi_d;
    acc_q   <= acc_d;
    count_q <= count_d;
    esc_q   <= esc_d;
  end

  assign red  = ColorFull - 8'(count_q[7:0] * RedStep);
  assign blue = ColorFull - 8'(count_q[7:0] * BlueStep);

  always_comb begin
    out_d.iteration_count = count_q;
    out_d.escaped         = esc_q;
    if (count_q == limit_q) begin
      out_d.pixel_color = '0;
    end else begin
      out_d.pixel_color = {red, ColorFull, blue};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.out_load) begin
      out_q <= out_d;
    end
  end

  assign in_stall_o  = ctl.busy;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_escaped_colored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.escaped) |-> (out_data_o.pixel_color[15:8] == ColorFull))
    else $error("escaped point delivered as black");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed or dropped");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an accepted transaction");

endmodule

FILE: rtl/etf_mul.sv
module etf_mul import etf_pkg::*; #(
  parameter int OpW = CoordWidth
) (
  input  logic                    clk_i,
  input  logic signed [OpW-1:0]   a_i,
  input  logic signed [OpW-1:0]   b_i,
  output logic signed [2*OpW-1:0] p_o
);

  logic signed [2*OpW-1:0] p_d;
  logic signed [2*OpW-1:0] p_q;

  assign p_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

FILE: rtl/etf_ctrl.sv
module etf_ctrl import etf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  etf_sts_t sts_i,
  output etf_ctl_t ctl_o
);

  etf_state_e state_d;
  etf_state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (sts_i.in_valid) begin
          state_d = sts_i.limit_zero ? ST_FIN : ST_MRR;
        end
      end
      ST_MRR: state_d = ST_MII;
      ST_MII: state_d = ST_MRI;
      ST_MRI: state_d = ST_CHK;
      ST_CHK: state_d = sts_i.over_two ? ST_FIN : ST_SRR;
      ST_SRR: state_d = ST_SII;
      ST_SII: state_d = ST_CMP;
      ST_CMP: begin
        if (sts_i.sum_over || sts_i.count_last) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_MRR;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl_o = '0;
    ctl_o.busy = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: ctl_o.load_in = sts_i.in_valid;
      ST_MRR:  ;
      ST_MII: begin
        ctl_o.sel_a_imag = 1'b1;
        ctl_o.sel_b_imag = 1'b1;
        ctl_o.acc_load   = 1'b1;
      end
      ST_MRI: begin
        ctl_o.sel_b_imag = 1'b1;
        ctl_o.acc_sub    = 1'b1;
      end
      ST_CHK: begin
        ctl_o.z_update = 1'b1;
        ctl_o.esc_set  = sts_i.over_two;
      end
      ST_SRR:  ;
      ST_SII: begin
        ctl_o.sel_a_imag = 1'b1;
        ctl_o.sel_b_imag = 1'b1;
        ctl_o.acc_load   = 1'b1;
      end
      ST_CMP: begin
        ctl_o.esc_set   = sts_i.sum_over;
        ctl_o.count_inc = !sts_i.sum_over;
      end
      ST_FIN:  ctl_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && sts_i.in_valid) |=> (state_q == ST_MRR || state_q == ST_FIN))
    else $error("accepted transaction did not start an update or finish");

  a_chk_after_mri: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHK) |-> ($past(state_q) == ST_MRI))
    else $error("range check reached without the cross product");

  a_cmp_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |=> (state_q == ST_FIN || state_q == ST_MRR))
    else $error("bad exit from magnitude compare");

endmodule

FILE: verif/tb_escape_time_fractal_pixel.sv
`timescale 1ns / 1ps

module tb_escape_time_fractal_pixel import etf_pkg::*;;

  localparam int ONE           = 1 << FracBitsDef;
  localparam int TWO           = 2 * ONE;
  localparam int PHASE_ITEMS   = 110;
  localparam int MAX_IDLE      = 4;
  localparam logic [CountWidth-1:0] LIMIT_MAX = '1;

  class pixel_scoreboard;
    logic [CountWidth-1:0] limit;
    etf_out_t              expected_pixels[$];
    int                    failures;

    function new();
      limit    = 16'd64;
      failures = 0;
    endfunction

    function etf_out_t predict_pixel(etf_in_t pt);
      logic signed [127:0] zr, zi, cr, ci, nr, ni;
      logic signed [127:0] bound, four;
      int unsigned         count;
      logic                esc;
      logic [7:0]          red, blue;
      etf_out_t            res;
      bound = 128'sd2 <<< FracBitsDef;
      four  = 128'sd4 <<< (2 * FracBitsDef);
      cr    = $signed(pt.c_real);
      ci    = $signed(pt.c_imag);
      zr    = $signed(pt.start_real);
      zi    = $signed(pt.start_imag);
      count = 0;
      esc   = 1'b0;
      while (count < limit) begin
        // floor of the scaled product, then add c at full width
        nr = ((zr * zr - zi * zi) >>> FracBitsDef) + cr;
        ni = ((zr * zi) >>> (FracBitsDef - 1)) + ci;
        if (nr > bound || nr < -bound || ni > bound || ni < -bound ||
            nr * nr + ni * ni > four) begin
          esc = 1'b1;
          break;
        end
        zr = nr;
        zi = ni;
        count++;
      end
      red  = 8'(32'd255 - 32'd15 * count);
      blue = 8'(32'd255 - 32'd5 * count);
      res.iteration_count = CountWidth'(count);
      res.escaped         = esc;
      res.pixel_color     = (count == limit) ? '0 : {red, 8'hFF, blue};
      return res;
    endfunction

    function void note_point(etf_in_t pt);
      expected_pixels.push_back(predict_pixel(pt));
    endfunction

    function void check_pixel(etf_out_t got);
      etf_out_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: result with nothing expected: count %0d escaped %0b color %06h",
                 $time, got.iteration_count, got.escaped, got.pixel_color);
        failures++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.iteration_count !== want.iteration_count) begin
        $display("%0t: iteration_count expected %0d actual %0d",
                 $time, want.iteration_count, got.iteration_count);
        failures++;
      end
      if (got.escaped !== want.escaped) begin
        $display("%0t: escaped expected %0b actual %0b", $time, want.escaped, got.escaped);
        failures++;
      end
      if (got.pixel_color !== want.pixel_color) begin
        $display("%0t: pixel_color expected %06h actual %06h",
                 $time, want.pixel_color, got.pixel_color);
        failures++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  etf_in_t               in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  etf_out_t              out_data_o;
  logic                  cfg_wr_en_i;
  logic [CountWidth-1:0] cfg_wr_data_i;

  pixel_scoreboard sb;
  int              in_calm;
  longint          cycle_budget = 0;
  longint          cycle_count;

  escape_time_fractal_pixel dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // idle cycles before the next transaction, with runs of back-to-back ones
  function automatic int idle_draw(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MAX_IDLE);
  endfunction

  function automatic logic [CoordWidth-1:0] fx(real v);
    return $rtoi(v * ONE);
  endfunction

  function automatic etf_in_t pt4(logic [CoordWidth-1:0] cr, logic [CoordWidth-1:0] ci,
                                  logic [CoordWidth-1:0] sr, logic [CoordWidth-1:0] si);
    etf_in_t pt;
    pt.c_real     = cr;
    pt.c_imag     = ci;
    pt.start_real = sr;
    pt.start_imag = si;
    return pt;
  endfunction

  function automatic logic [CoordWidth-1:0] edge_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return TWO;
      4:       return -TWO;
      5:       return TWO + 1;
      6:       return -TWO - 1;
      default: return ONE;
    endcase
  endfunction

  function automatic etf_in_t random_point();
    etf_in_t     pt;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      // points around the set, mostly mandelbrot starts
      pt.c_real = $urandom_range(0, 13 * (ONE / 5)) - 2 * ONE;
      pt.c_imag = $urandom_range(0, 12 * (ONE / 5)) - 6 * (ONE / 5);
      if ($urandom_range(0, 2) == 0) begin
        pt.start_real = $urandom_range(0, 3 * ONE) - 3 * (ONE / 2);
        pt.start_imag = $urandom_range(0, 3 * ONE) - 3 * (ONE / 2);
      end else begin
        pt.start_real = '0;
        pt.start_imag = '0;
      end
    end else if (pick < 88) begin
      pt = pt4($urandom, $urandom, $urandom, $urandom);
    end else begin
      pt = pt4(edge_value(), edge_value(), edge_value(), edge_value());
    end
    return pt;
  endfunction

  // real part beyond two with a zero start leaves on the first update
  function automatic etf_in_t fast_escape_point();
    etf_in_t pt;
    pt.c_real = $urandom_range(TWO + 1, 32'h7FFF_FFFF);
    if ($urandom_range(0, 1) == 1) pt.c_real = -pt.c_real;
    pt.c_imag     = $urandom;
    pt.start_real = '0;
    pt.start_imag = '0;
    return pt;
  endfunction

  task automatic send_point(input etf_in_t pt);
    int gap;
    gap = idle_draw(in_calm);
    cycle_budget += 7 * longint'(sb.limit) + 24;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= pt;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_point(pt);
    @(negedge clk_i);
  endtask

  task automatic set_limit(input logic [CountWidth-1:0] value);
    in_valid_i <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b0;
    sb.limit = value;
    @(negedge clk_i);
  endtask

  initial begin : result_sink
    int hold;
    int calm;
    calm = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = idle_draw(calm);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_pixel(out_data_o);
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count <= 4 * cycle_budget + 100000) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[escape_time_fractal_pixel] ERROR");
    $finish;
  end

  initial begin : stimulus
    int plan[16];
    int lim;
    sb            = new();
    in_calm       = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_stall_i   = 1'b0;
    cfg_wr_en_i   = 1'b0;
    cfg_wr_data_i = '0;
    plan = '{1, 0, 2, 65535, 16, -1, 48, -1, 64, 7, -1, 32, -1, 1, -1, 40};
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed points under the reset limit
    send_point(pt4(0, 0, 0, 0));
    send_point(pt4(fx(-2.0), 0, 0, 0));
    send_point(pt4(fx(2.0), 0, 0, 0));
    send_point(pt4(TWO + 1, 0, 0, 0));
    send_point(pt4(0, -TWO - 1, 0, 0));
    send_point(pt4(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
    send_point(pt4(32'h8000_0000, 32'h8000_0000, 0, 0));
    send_point(pt4(0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
    send_point(pt4(0, 0, 32'h8000_0000, 32'h7FFF_FFFF));
    send_point(pt4(fx(0.25), 0, 0, 0));
    send_point(pt4(fx(-0.75), fx(0.1), 0, 0));
    send_point(pt4(0, ONE, 0, 0));
    send_point(pt4(fx(0.4), 0, 0, 0));
    send_point(pt4(fx(-0.8), fx(0.156), fx(0.5), fx(0.5)));
    send_point(pt4(0, fx(2.5), 0, 0));
    send_point(pt4(fx(1.5), fx(1.5), 0, 0));
    send_point(pt4(fx(-1.0), 0, fx(-1.99), fx(0.01)));

    foreach (plan[p]) begin
      lim = (plan[p] < 0) ? $urandom_range(3, 48) : plan[p];
      set_limit(CountWidth'(lim));
      if (CountWidth'(lim) == LIMIT_MAX) begin
        // widest limit: quick escapes, then two points beyond the set and one that runs to the limit
        repeat (40) send_point(fast_escape_point());
        send_point(pt4(fx(0.4), 0, 0, 0));
        send_point(pt4(fx(0.3), 0, 0, 0));
        send_point(pt4(0, 0, 0, 0));
      end else begin
        repeat (PHASE_ITEMS) send_point(random_point());
      end
    end

    in_valid_i <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (sb.failures == 0 && sb.expected_pixels.size() == 0) begin
      $display("[escape_time_fractal_pixel] OK");
    end else begin
      $display("[escape_time_fractal_pixel] ERROR");
    end
    $finish;
  end

endmodule
